/* sv/tbi_pkg.sv */
// ----------------------------------------------------------------------------
// tbi_pkg
// Shared types, constants and codes of the table bracket interpolate block.
// ----------------------------------------------------------------------------
package tbi_pkg;

  // Default geometry of the table
  localparam int DepthDef     = 128;
  localparam int ColumnsDef   = 16;
  localparam int ValueBitsDef = 32;

  // Fixed field widths
  localparam int ValW  = 32;
  localparam int ColW  = 4;
  localparam int PosW  = 7;
  localparam int CfgIW = 2;
  localparam int CfgDW = 7;

  // Interpolation divider widths
  localparam int DenW = ValW + 1;
  localparam int QuoW = ValW + 2;
  localparam int NumW = 2 * DenW;

  // Configuration register indexes
  typedef enum logic [CfgIW-1:0] {
    CFG_KEY_COLUMN     = 2'd0,
    CFG_FIRST_POSITION = 2'd1,
    CFG_LAST_POSITION  = 2'd2,
    CFG_JUST_GET       = 2'd3
  } cfg_idx_e;

  // Query sequencer states
  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_RHI   = 14'b00000000000010,
    ST_RANGE = 14'b00000000000100,
    ST_EVAL  = 14'b00000000001000,
    ST_HIT   = 14'b00000000010000,
    ST_Y1    = 14'b00000000100000,
    ST_Y2    = 14'b00000001000000,
    ST_JG1   = 14'b00000010000000,
    ST_JG2   = 14'b00000100000000,
    ST_MUL   = 14'b00001000000000,
    ST_DIV   = 14'b00010000000000,
    ST_DWAIT = 14'b00100000000000,
    ST_LERP  = 14'b01000000000000,
    ST_NF    = 14'b10000000000000
  } state_e;

  // One result item
  typedef struct packed {
    logic signed [ValW-1:0] result_value;
    logic                   found;
    logic                   exact_match;
    logic [PosW-1:0]        lower_position;
    logic                   last;
  } res_t;

  // Divider control and status
  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [QuoW-1:0] quot;
  } div_rsp_t;

endpackage

/* sv/tbi_if.sv */
// ----------------------------------------------------------------------------
// tbi_req_if / tbi_res_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tbi_req_if
  import tbi_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [ColW-1:0]        column;
  logic [PosW-1:0]        position;
  logic signed [ValW-1:0] entry_value;
  logic signed [ValW-1:0] search_key;
  logic [ColW-1:0]        target_column;

  modport source (output valid, kind, column, position, entry_value, search_key,
                  target_column, input ready);
  modport sink (input valid, kind, column, position, entry_value, search_key,
                target_column, output ready);
endinterface

interface tbi_res_if
  import tbi_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] result_value;
  logic                   found;
  logic                   exact_match;
  logic [PosW-1:0]        lower_position;
  logic                   last;

  modport source (output valid, result_value, found, exact_match, lower_position,
                  last, input ready);
  modport sink (input valid, result_value, found, exact_match, lower_position,
                last, output ready);
endinterface

/* sv/tbi_mem.sv */
// ----------------------------------------------------------------------------
// tbi_mem
// Table store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tbi_mem #(
  parameter int WORDS = 2048,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(WORDS)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(WORDS)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [WORDS];
  logic [WIDTH-1:0] rdata_q;

  // Write entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read entry, hold data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/tbi_div.sv */
// ----------------------------------------------------------------------------
// tbi_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tbi_div
  import tbi_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CntW = $clog2(QuoW + 1);

  logic [QuoW-1:0] rem_q, rem_d;
  logic [QuoW-1:0] sh_q, sh_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [QuoW-1:0] trial;
  logic            ge;

  // Load a new division on start, else shift in the next numerator bit and try to subtract
  always_comb begin
    trial = {rem_q[QuoW-2:0], sh_q[QuoW-1]};
    ge    = trial >= QuoW'(den_q);
    rem_d = rem_q;
    sh_d  = sh_q;
    den_d = den_q;
    cnt_d = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = QuoW'(req_i.num[NumW-1:QuoW]);
      sh_d  = req_i.num[QuoW-1:0];
      den_d = req_i.den;
      cnt_d = CntW'(QuoW);
    end else if (cnt_q != '0) begin
      rem_d = ge ? trial - QuoW'(den_q) : trial;
      sh_d  = {sh_q[QuoW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = sh_q;

endmodule

/* sv/table_bracket_interpolate_core.sv */
// ----------------------------------------------------------------------------
// table_bracket_interpolate_core
// A write request stores one table entry with no result. A query reads the
// first and last key entries, checks the key lies between them and bisects with
// at most clog2(DEPTH)+1 probes; a hit returns the target column value, just-get
// both bracket values, else it interpolates (multiply, divide). One request is
// worked at a time; the single table read port and the divider set the rate.
// Reset sets control and config registers to defaults; the table is not cleared.
// ----------------------------------------------------------------------------
module table_bracket_interpolate_core
  import tbi_pkg::*;
#(
  parameter int DEPTH      = DepthDef,
  parameter int COLUMNS    = ColumnsDef,
  parameter int VALUE_BITS = ValueBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgIW-1:0] cfg_idx_i,
  input  logic [CfgDW-1:0] cfg_data_i,
  tbi_req_if.sink          req_i,
  tbi_res_if.source        res_o
);

  localparam int Words = COLUMNS * DEPTH;
  localparam int AW    = $clog2(Words);
  localparam int Lim   = $clog2(DEPTH) + 1;
  localparam int NW    = $clog2(Lim + 1);

  // Configuration
  logic [ColW-1:0] kc_q;
  logic [PosW-1:0] first_q, last_q;
  logic            jg_q;

  // Sequencer
  state_e                 state_q, state_d;
  logic [PosW-1:0]        lo_q, lo_d, hi_q, hi_d, hitpos_q, hitpos_d;
  logic signed [ValW-1:0] v1_q, v1_d, v3_q, v3_d, key_q, key_d;
  logic signed [ValW-1:0] y1_q, y1_d, y2_q, y2_d;
  logic [ColW-1:0]        tc_q, tc_d;
  logic                   desc_q, desc_d;
  logic [NW-1:0]          n_q, n_d;
  logic [NumW-1:0]        num_q, num_d;
  logic [DenW-1:0]        adx_q, adx_d;
  logic                   neg_q, neg_d, triv_q, triv_d;

  // Memory access
  logic                   rd_en, wr_en;
  logic [ColW-1:0]        rd_col;
  logic [PosW-1:0]        rd_pos;
  logic [VALUE_BITS-1:0]  mem_rdata;
  logic signed [ValW-1:0] rd_val;

  // Output register
  res_t res_q, res_d;
  logic res_vld_q, res_vld_d;
  logic out_free, out_load;

  div_req_t div_req;
  div_rsp_t div_rsp;

  function automatic logic [AW-1:0] addr_of(input logic [ColW-1:0] c,
                                             input logic [PosW-1:0] p);
    return AW'(c % COLUMNS) * AW'(DEPTH) + AW'(p % DEPTH);
  endfunction

  // Bisection and interpolation helpers
  logic [PosW:0]          mid_sum, nmid_sum;
  logic [PosW-1:0]        mid, nmid;
  logic                   up_hi, up_lo;
  logic signed [ValW:0]   dy, dk, dx;
  logic [DenW-1:0]        ady, adk, adx, adk_c;
  logic [NumW-1:0]        prod;
  logic [ValW-1:0]        qv;
  logic signed [ValW-1:0] lerp;
  logic signed [ValW-1:0] in_key;

  assign rd_val  = ValW'($signed(mem_rdata));
  assign in_key  = ValW'($signed(req_i.search_key[VALUE_BITS-1:0]));
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[PosW:1];
  assign nmid_sum = {1'b0, lo_d} + {1'b0, hi_d};
  assign nmid     = nmid_sum[PosW:1];

  // Interpolation operands
  always_comb begin
    dy  = {y2_q[ValW-1], y2_q} - {y1_q[ValW-1], y1_q};
    dk  = {key_q[ValW-1], key_q} - {v1_q[ValW-1], v1_q};
    dx  = {v3_q[ValW-1], v3_q} - {v1_q[ValW-1], v1_q};
    ady = dy[ValW] ? DenW'(-dy) : DenW'(dy);
    adk = dk[ValW] ? DenW'(-dk) : DenW'(dk);
    adx = dx[ValW] ? DenW'(-dx) : DenW'(dx);
    adk_c = (adk > adx) ? adx : adk;
  end

  // Full-width product of the magnitudes
  assign prod = ady * adk_c;

  assign qv   = div_rsp.quot[ValW-1:0];
  assign lerp = triv_q ? y1_q : (neg_q ? y1_q - $signed(qv) : y1_q + $signed(qv));

  assign out_free  = !res_vld_q || res_o.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    hitpos_d = hitpos_q;
    v1_d     = v1_q;
    v3_d     = v3_q;
    key_d    = key_q;
    y1_d     = y1_q;
    y2_d     = y2_q;
    tc_d     = tc_q;
    desc_d   = desc_q;
    n_d      = n_q;
    num_d    = num_q;
    adx_d    = adx_q;
    neg_d    = neg_q;
    triv_d   = triv_q;
    rd_en    = 1'b0;
    rd_col   = kc_q;
    rd_pos   = lo_q;
    wr_en    = 1'b0;
    out_load = 1'b0;
    res_d    = res_q;
    div_req.start = 1'b0;
    div_req.num   = num_q;
    div_req.den   = adx_q;
    up_hi = 1'b0;
    up_lo = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          if (!req_i.kind) begin
            wr_en = 1'b1;
          end else begin
            key_d = in_key;
            tc_d  = req_i.target_column;
            lo_d  = first_q;
            hi_d  = last_q;
            if (first_q > last_q) begin
              state_d = ST_NF;
            end else begin
              rd_en   = 1'b1;
              rd_pos  = first_q;
              state_d = ST_RHI;
            end
          end
        end
      end
      ST_RHI: begin
        v1_d    = rd_val;
        rd_en   = 1'b1;
        rd_pos  = hi_q;
        state_d = ST_RANGE;
      end
      ST_RANGE: begin
        v3_d   = rd_val;
        desc_d = v1_q > rd_val;
        n_d    = '0;
        if ((v1_q > rd_val) ? (rd_val <= key_q && key_q <= v1_q)
                            : (v1_q <= key_q && key_q <= rd_val)) begin
          rd_en   = 1'b1;
          rd_pos  = mid;
          state_d = ST_EVAL;
        end else begin
          state_d = ST_NF;
        end
      end
      ST_EVAL: begin
        // Check ends and midpoint, then narrow the interval
        if (desc_q) begin
          up_hi = (v3_q <= key_q) && (key_q >= rd_val);
          up_lo = !up_hi && (key_q <= rd_val) && (key_q <= v1_q);
        end else begin
          up_hi = (v1_q <= key_q) && (key_q <= rd_val);
          up_lo = !up_hi && (key_q >= rd_val) && (key_q <= v3_q);
        end
        if (key_q == v1_q || key_q == rd_val || key_q == v3_q) begin
          hitpos_d = (key_q == v1_q) ? lo_q : ((key_q == rd_val) ? mid : hi_q);
          rd_en    = 1'b1;
          rd_col   = tc_q;
          rd_pos   = hitpos_d;
          state_d  = ST_HIT;
        end else if ((hi_q - lo_q) == PosW'(1)) begin
          rd_en   = 1'b1;
          rd_col  = tc_q;
          rd_pos  = lo_q;
          state_d = ST_Y1;
        end else begin
          if (up_hi) begin
            hi_d = mid;
            v3_d = rd_val;
          end else if (up_lo) begin
            lo_d = mid;
            v1_d = rd_val;
          end
          n_d = n_q + 1'b1;
          if (n_d == NW'(Lim)) begin
            state_d = ST_NF;
          end else begin
            rd_en  = 1'b1;
            rd_pos = nmid;
          end
        end
      end
      ST_HIT: begin
        if (out_free) begin
          out_load = 1'b1;
          res_d    = '{rd_val, 1'b1, 1'b1, hitpos_q, 1'b1};
          state_d  = ST_IDLE;
        end
      end
      ST_Y1: begin
        y1_d    = rd_val;
        rd_en   = 1'b1;
        rd_col  = tc_q;
        rd_pos  = hi_q;
        state_d = ST_Y2;
      end
      ST_Y2: begin
        y2_d    = rd_val;
        state_d = jg_q ? ST_JG1 : ST_MUL;
      end
      ST_JG1: begin
        if (out_free) begin
          out_load = 1'b1;
          res_d    = '{y1_q, 1'b1, 1'b0, lo_q, 1'b0};
          state_d  = ST_JG2;
        end
      end
      ST_JG2: begin
        if (out_free) begin
          out_load = 1'b1;
          res_d    = '{y2_q, 1'b1, 1'b0, lo_q, 1'b1};
          state_d  = ST_IDLE;
        end
      end
      ST_MUL: begin
        // Rounded numerator |dy|*min(|dk|,|dx|) + |dx|/2
        num_d   = prod + NumW'(adx >> 1);
        adx_d   = adx;
        neg_d   = (dy[ValW] != dk[ValW]) != dx[ValW];
        triv_d  = (dx == '0) || (dy == '0) || (dk == '0);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        div_req.start = !triv_q;
        state_d = triv_q ? ST_LERP : ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_rsp.done) begin
          state_d = ST_LERP;
        end
      end
      ST_LERP: begin
        if (out_free) begin
          out_load = 1'b1;
          res_d    = '{lerp, 1'b1, 1'b0, lo_q, 1'b1};
          state_d  = ST_IDLE;
        end
      end
      ST_NF: begin
        if (out_free) begin
          out_load = 1'b1;
          res_d    = '{'0, 1'b0, 1'b0, '0, 1'b1};
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: load wins, otherwise drop on handshake
  always_comb begin
    res_vld_d = res_vld_q;
    if (out_load) begin
      res_vld_d = 1'b1;
    end else if (res_o.ready) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      res_vld_q <= 1'b0;
      n_q       <= '0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
      n_q       <= n_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kc_q    <= '0;
      first_q <= '0;
      last_q  <= '1;
      jg_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY_COLUMN:     kc_q    <= cfg_data_i[ColW-1:0];
        CFG_FIRST_POSITION: first_q <= cfg_data_i[PosW-1:0];
        CFG_LAST_POSITION:  last_q  <= cfg_data_i[PosW-1:0];
        CFG_JUST_GET:       jg_q    <= cfg_data_i[0];
        default:            jg_q    <= jg_q;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    hitpos_q <= hitpos_d;
    v1_q     <= v1_d;
    v3_q     <= v3_d;
    key_q    <= key_d;
    y1_q     <= y1_d;
    y2_q     <= y2_d;
    tc_q     <= tc_d;
    desc_q   <= desc_d;
    num_q    <= num_d;
    adx_q    <= adx_d;
    neg_q    <= neg_d;
    triv_q   <= triv_d;
    res_q    <= res_d;
  end

  tbi_mem #(
    .WORDS (Words),
    .WIDTH (VALUE_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (addr_of(req_i.column, req_i.position)),
    .wdata_i (req_i.entry_value[VALUE_BITS-1:0]),
    .re_i    (rd_en),
    .raddr_i (addr_of(rd_col, rd_pos)),
    .rdata_o (mem_rdata)
  );

  tbi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign res_o.valid          = res_vld_q;
  assign res_o.result_value   = res_q.result_value;
  assign res_o.found          = res_q.found;
  assign res_o.exact_match    = res_q.exact_match;
  assign res_o.lower_position = res_q.lower_position;
  assign res_o.last           = res_q.last;

endmodule

/* sv/tbi_checker.sv */
// ----------------------------------------------------------------------------
// tbi_port_checks
// Port-level checks of the result channel, bound to table_bracket_interpolate_core.
// ----------------------------------------------------------------------------
module tbi_port_checks
  import tbi_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   res_valid,
  input logic                   res_ready,
  input logic signed [ValW-1:0] result_value,
  input logic                   found,
  input logic                   exact_match,
  input logic [PosW-1:0]        lower_position,
  input logic                   last
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(result_value) && $stable(last))
    else $error("stalled result changed");

  // Not-found result is all zero and final
  a_nf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !found |-> result_value == '0 && !exact_match &&
                            lower_position == '0 && last)
    else $error("bad not-found result");

  // Exact hit is a single final found result
  a_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && exact_match |-> found && last)
    else $error("bad exact hit result");

  // First just-get result is followed at once by the final one
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready && !last |=> res_valid && last && found && !exact_match)
    else $error("missing second bracket result");

endmodule

bind table_bracket_interpolate_core tbi_port_checks u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid      (res_o.valid),
  .res_ready      (res_o.ready),
  .result_value   (res_o.result_value),
  .found          (res_o.found),
  .exact_match    (res_o.exact_match),
  .lower_position (res_o.lower_position),
  .last           (res_o.last)
);
